[hdl/deq_pkg.sv]
package deq_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_REAR   = 3'd3;
  localparam logic [2:0] MODE_DUMP       = 3'd4;

  localparam logic [2:0] KIND_DONE        = 3'd0;
  localparam logic [2:0] KIND_UNDERFLOW   = 3'd1;
  localparam logic [2:0] KIND_OVERFLOW    = 3'd2;
  localparam logic [2:0] KIND_DUMP_ENTRY  = 3'd3;
  localparam logic [2:0] KIND_DUMP_EMPTY  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + (IDX_W+1)'(1);
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = '0;
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = idx - IDX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off[IDX_W-1:0]};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[hdl/double_ended_queue_unit.sv]
// Bounded double-ended queue of signed 32-bit values in a circular store.
// Input channel (in_valid, in_stall, in_mode, in_value) takes one command
// per transaction: push front, push rear, pop front, pop rear or dump.
// Output channel (out_valid, out_stall, out_kind, out_entry, out_last)
// returns status and dump-entry results from a single output register.
// A push or pop gives one result, visible the cycle after acceptance; a
// new command is taken every cycle while no dump runs and the output
// register is free or being emptied in the same cycle. A dump reads the
// store, one synchronous RAM port read per entry, from front to rear:
// the first read is issued in ST_RD; each entry passes the RAM read
// register into the output register, and the rest follow one per cycle
// while out_stall is low. in_stall stays high during the dump. A dump of
// an empty queue gives one result, visible the cycle after acceptance.
// Unused mode codes are consumed without a result.
// Synchronous reset empties the queue; the store itself is not cleared.
// When out_stall is high with a valid result, the result register holds
// and no new command is accepted until the result has been taken.
module double_ended_queue_unit
  import deq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic signed [31:0] out_entry,
  output logic               out_last
);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_kind_r, out_kind_nxt;
  logic [DATA_W-1:0] out_entry_r, out_entry_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              in_acc;
  logic              full, empty;
  logic              dump_last;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic [CNT_W-1:0]  rd_off;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign full      = (occ_r == CNT_W'(DEPTH));
  assign empty     = (occ_r == '0);
  assign dump_last = ((cnt_r + CNT_W'(1)) == occ_r);
  assign rd_off    = (state_r == ST_RD) ? cnt_r : cnt_r + CNT_W'(1);
  assign rd_addr   = slot_at(head_r, rd_off);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_entry_nxt = out_entry_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    rd_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_kind_nxt  = KIND_DONE;
          out_entry_nxt = '0;
          out_last_nxt  = 1'b1;
          case (in_mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_kind_nxt = KIND_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                occ_nxt = occ_r + CNT_W'(1);
                if (in_mode == MODE_PUSH_FRONT) begin
                  wr_addr  = wrap_dec(head_r);
                  head_nxt = wrap_dec(head_r);
                end else begin
                  wr_addr = slot_at(head_r, occ_r);
                end
              end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_kind_nxt = KIND_UNDERFLOW;
              end else begin
                occ_nxt = occ_r - CNT_W'(1);
                if (in_mode == MODE_POP_FRONT) begin
                  head_nxt = wrap_inc(head_r);
                end
              end
            end
            MODE_DUMP: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_DUMP_EMPTY;
              end else begin
                cnt_nxt   = '0;
                state_nxt = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DUMP_ENTRY;
          out_entry_nxt = rd_data;
          out_last_nxt  = dump_last;
          if (dump_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_entry_r <= out_entry_nxt;
    out_last_r  <= out_last_nxt;
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (DATA_W'(in_value)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_entry = signed'(out_entry_r);
  assign out_last  = out_last_r;

endmodule

[hdl/deq_ram.sv]
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/deq_chk.sv]
module deq_chk
  import deq_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         in_mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_kind,
  input logic signed [31:0] out_entry,
  input logic               out_last
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result visible right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_kind) && $stable(out_entry) && $stable(out_last))
    else $error("Stalled result transaction changed.");

  a_push_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_mode == MODE_PUSH_FRONT || in_mode == MODE_PUSH_REAR ||
     in_mode == MODE_POP_FRONT || in_mode == MODE_POP_REAR)
    |=> out_valid && out_last && out_kind != KIND_DUMP_ENTRY)
    else $error("Push or pop did not give its status the next cycle.");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DUMP_ENTRY |-> out_last && out_entry == 0)
    else $error("Status result not single or carries a nonzero entry.");

endmodule

bind double_ended_queue_unit deq_chk u_deq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_mode   (in_mode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_entry (out_entry),
  .out_last  (out_last)
);

[verif/tb_double_ended_queue_unit.sv]
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;
  import deq_pkg::*;

  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] value;
    int unsigned        idle_pct;
    int unsigned        stall_pct;
  } command_t;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] entry;
    logic               last;
  } status_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_mode = MODE_PUSH_FRONT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_kind;
  logic signed [31:0] out_entry;
  logic               out_last;

  command_t           pending_cmds[$];
  status_t            expected_status[$];
  logic signed [31:0] deque_mem[DEPTH];
  logic [IDX_W-1:0]   front_idx = '0;
  int unsigned        entry_count = 0;
  int unsigned        stall_pct = 0;
  int unsigned        error_count = 0;
  command_t           next_cmd;
  status_t            want;

  double_ended_queue_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_entry (out_entry),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_status(logic [2:0] kind, logic signed [31:0] entry,
                                      logic last);
    status_t s;
    s.kind  = kind;
    s.entry = entry;
    s.last  = last;
    expected_status.push_back(s);
  endfunction

  function automatic void apply_command(logic [2:0] mode, logic signed [31:0] value);
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (entry_count >= DEPTH) begin
          push_status(KIND_OVERFLOW, '0, 1'b1);
        end else begin
          if (mode == MODE_PUSH_FRONT) begin
            front_idx = (front_idx == '0) ? IDX_W'(DEPTH - 1) : front_idx - 1'b1;
            deque_mem[front_idx] = value;
          end else begin
            deque_mem[IDX_W'((front_idx + entry_count) % DEPTH)] = value;
          end
          entry_count++;
          push_status(KIND_DONE, '0, 1'b1);
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (entry_count == 0) begin
          push_status(KIND_UNDERFLOW, '0, 1'b1);
        end else begin
          if (mode == MODE_POP_FRONT) begin
            front_idx = IDX_W'((front_idx + 1) % DEPTH);
          end
          entry_count--;
          push_status(KIND_DONE, '0, 1'b1);
        end
      end
      MODE_DUMP: begin
        if (entry_count == 0) begin
          push_status(KIND_DUMP_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < entry_count; i++) begin
            push_status(KIND_DUMP_ENTRY, deque_mem[IDX_W'((front_idx + i) % DEPTH)],
                        (i + 1) == entry_count);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_cmd(logic [2:0] mode, logic signed [31:0] value,
                                  int unsigned idle_pct, int unsigned hold_pct);
    command_t c;
    c.mode      = mode;
    c.value     = value;
    c.idle_pct  = idle_pct;
    c.stall_pct = hold_pct;
    pending_cmds.push_back(c);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_mode <= next_cmd.mode;
        in_value <= next_cmd.value;
        stall_pct <= next_cmd.stall_pct;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Results are checked before the command accepted at the same edge is
  // applied, so a result can only match an earlier transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d entry %0d last %0b",
                   $time, out_kind, out_entry, out_last);
          error_count++;
        end else begin
          want = expected_status.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, out_kind);
            error_count++;
          end
          if (out_entry !== want.entry) begin
            $display("%0t: entry mismatch, expected %0d, got %0d",
                     $time, want.entry, out_entry);
            error_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, out_last);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(in_mode, in_value);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : stimulus
    logic [2:0]         mode;
    logic signed [31:0] value;
    int unsigned        idle_pct;
    int unsigned        hold_pct;
    int unsigned        pick;
    bit                 filling;

    add_cmd(MODE_POP_FRONT, 32'sh0000_1234, 0, 0);
    add_cmd(MODE_POP_REAR, 32'sh0000_4321, 0, 0);
    add_cmd(MODE_DUMP, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_PUSH_FRONT, 32'sh7FFF_FFFF, 0, 0);
    add_cmd(MODE_PUSH_REAR, 32'sh8000_0000, 0, 0);
    add_cmd(MODE_PUSH_FRONT, -32'sd1, 0, 0);
    add_cmd(MODE_PUSH_REAR, 32'sh0000_0000, 0, 0);
    add_cmd(3'd5, 32'sh1234_5678, 0, 0);
    add_cmd(MODE_DUMP, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_POP_FRONT, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_POP_REAR, 32'sh0000_0000, 0, 0);
    add_cmd(3'd6, 32'sh0F0F_0F0F, 0, 0);
    add_cmd(MODE_PUSH_REAR, 32'sh5555_5555, 0, 0);
    add_cmd(MODE_PUSH_FRONT, 32'shAAAA_AAAA, 0, 0);
    add_cmd(3'd7, -32'sd1, 0, 0);
    add_cmd(MODE_DUMP, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_POP_REAR, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_POP_REAR, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_POP_FRONT, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_POP_FRONT, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_POP_REAR, 32'sh0000_0000, 0, 0);
    add_cmd(MODE_DUMP, 32'sh0000_0000, 0, 0);

    // Long push-heavy stretches fill the queue to overflow, and
    // pop-heavy stretches drain it back to underflow.
    for (int n = 0; n < 140; n++) begin
      case (n / 35)
        0: begin
          idle_pct = 0;
          hold_pct = 0;
        end
        1: begin
          idle_pct = 52;
          hold_pct = 0;
        end
        2: begin
          idle_pct = 0;
          hold_pct = 52;
        end
        default: begin
          idle_pct = 6;
          hold_pct = 6;
        end
      endcase
      filling = ((n / 64) % 2) == 0;
      pick = $urandom_range(99);
      if (pick < 5) begin
        mode = 3'($urandom_range(7, 5));
      end else if (pick < 14) begin
        mode = MODE_DUMP;
      end else if ($urandom_range(99) < (filling ? 90 : 10)) begin
        mode = $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
      end else begin
        mode = $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
      end
      case ($urandom_range(9))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7FFF_FFFF;
        2: value = -32'sd1;
        3: value = 32'sh0000_0000;
        default: value = $urandom();
      endcase
      add_cmd(mode, value, idle_pct, hold_pct);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);

    if (error_count == 0 && expected_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("Verification failed");
    $finish;
  end

endmodule
